/* sv/set_assoc_lru_cache_tags_top_assert.svh */
`ifndef SET_ASSOC_LRU_CACHE_TAGS_TOP_ASSERT_SVH
`define SET_ASSOC_LRU_CACHE_TAGS_TOP_ASSERT_SVH

// same-cycle implication, checked on clk_i, off during reset
`define SLRU_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked on clk_i, off during reset
`define SLRU_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/slru_pkg.sv */
`default_nettype none

package slru_pkg;

  localparam int SETS    = 64;
  localparam int WAYS    = 16;
  localparam int SET_W   = $clog2(SETS);
  localparam int WAY_W   = $clog2(WAYS);
  localparam int ADDR_W  = 32;
  localparam int TAG_W   = 32;
  localparam int STAMP_W = 32;
  localparam int CNT_W   = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 5;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_OFFSET_WIDTH = 2'd0,
    CFG_INDEX_WIDTH  = 2'd1,
    CFG_WAYS_IN_USE  = 2'd2
  } cfg_idx_e;

  localparam logic [4:0] OFFSET_WIDTH_RST = 5'd2;
  localparam logic [2:0] INDEX_WIDTH_RST  = 3'd6;
  localparam logic [4:0] WAYS_IN_USE_RST  = 5'd4;

endpackage

`default_nettype wire

/* sv/slru_if.sv */
`default_nettype none

interface slru_req_if import slru_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [ADDR_W-1:0] address;

  modport source (output valid, output address, input ready);
  modport sink   (input valid, input address, output ready);
endinterface

interface slru_rsp_if import slru_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             hit;
  logic [WAY_W-1:0] way;
  logic             filled_empty;
  logic [CNT_W-1:0] hits_so_far;
  logic [CNT_W-1:0] misses_so_far;
  logic [CNT_W-1:0] accesses_so_far;

  modport source (output valid, output hit, output way, output filled_empty,
                  output hits_so_far, output misses_so_far, output accesses_so_far,
                  input ready);
  modport sink   (input valid, input hit, input way, input filled_empty,
                  input hits_so_far, input misses_so_far, input accesses_so_far,
                  output ready);
endinterface

interface slru_cfg_if import slru_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

/* sv/slru_victim.sv */
`default_nettype none

module slru_victim import slru_pkg::*; (
  input  wire logic                           clk_i,
  input  wire logic                           ld_i,
  input  wire logic [WAYS-1:0][STAMP_W-1:0]   stamp_i,
  input  wire logic [WAYS-1:0]                en_i,
  output logic      [WAY_W-1:0]               way_o
);

  localparam int L1 = WAYS / 2;
  localparam int L2 = WAYS / 4;
  localparam int L3 = WAYS / 8;

  typedef struct packed {
    logic               pres;
    logic [WAY_W-1:0]   idx;
    logic [STAMP_W-1:0] stamp;
  } cand_t;

  // left operand has the lower way, so it wins ties
  function automatic cand_t pick(input cand_t a, input cand_t b);
    cand_t r;
    r = a;
    if (!a.pres || (b.pres && (b.stamp < a.stamp))) r = b;
    return r;
  endfunction

  cand_t lv0 [WAYS];
  cand_t lv1 [L1];
  cand_t lv2 [L2];
  cand_t lv2_q [L2];
  cand_t lv3 [L3];
  cand_t best;

  // first two tree levels, registered
  always_comb begin
    for (int i = 0; i < WAYS; i++) begin
      lv0[i].pres  = en_i[i];
      lv0[i].idx   = WAY_W'(i);
      lv0[i].stamp = stamp_i[i];
    end
    for (int i = 0; i < L1; i++) lv1[i] = pick(lv0[2*i], lv0[2*i+1]);
    for (int i = 0; i < L2; i++) lv2[i] = pick(lv1[2*i], lv1[2*i+1]);
  end

  always_ff @(posedge clk_i) begin
    if (ld_i) begin
      for (int i = 0; i < L2; i++) lv2_q[i] <= lv2[i];
    end
  end

  // last two levels
  always_comb begin
    for (int i = 0; i < L3; i++) lv3[i] = pick(lv2_q[2*i], lv2_q[2*i+1]);
    best = pick(lv3[0], lv3[1]);
  end

  assign way_o = best.idx;

endmodule

`default_nettype wire

/* sv/set_assoc_lru_cache_tags_top.sv */
// flow: the accepting edge registers the set row read; the result register loads in S_LOOK
//   on a hit or empty-way fill, in S_EVICT when a valid way is evicted (the lru minimum
//   tree is registered midway); an untaken result holds both states. One address at a time:
//   the next waits for the read-modify-write of one set row in the single-port tag memory
// reset: control, counters and per-set row-valid flops clear at once, so every set reads
//   empty and no clearing pass is needed; config returns to offset 2, index 6, 4 ways
`default_nettype none

`include "set_assoc_lru_cache_tags_top_assert.svh"

module set_assoc_lru_cache_tags_top import slru_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  slru_req_if.sink   req_i,
  slru_rsp_if.source rsp_o,
  slru_cfg_if.sink   cfg_i
);

  // one memory row holds a whole set: tags, stamps, valid mask and access counter
  typedef struct packed {
    logic [CNT_W-1:0]                ctr;
    logic [WAYS-1:0]                 vld;
    logic [WAYS-1:0][STAMP_W-1:0]    stamp;
    logic [WAYS-1:0][TAG_W-1:0]      tag;
  } row_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOOK,
    S_EVICT
  } state_e;

  // ---------------------------------------------------------------- config
  logic [4:0] offset_w_q;
  logic [2:0] index_w_q;
  logic [4:0] ways_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_w_q <= OFFSET_WIDTH_RST;
      index_w_q  <= INDEX_WIDTH_RST;
      ways_q     <= WAYS_IN_USE_RST;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        CFG_OFFSET_WIDTH: offset_w_q <= cfg_i.data;
        CFG_INDEX_WIDTH:  index_w_q  <= cfg_i.data[2:0];
        CFG_WAYS_IN_USE:  ways_q     <= cfg_i.data;
        default: ;
      endcase
    end
  end

  // ways searched: zero acts as one, above WAYS clamps to WAYS
  logic [WAY_W:0]  ways_eff;
  logic [WAYS-1:0] way_en;

  always_comb begin
    ways_eff = ways_q;
    if (ways_q == '0) ways_eff = (WAY_W+1)'(1);
    else if (ways_q > (WAY_W+1)'(WAYS)) ways_eff = (WAY_W+1)'(WAYS);
    for (int i = 0; i < WAYS; i++) way_en[i] = ((WAY_W+1)'(i) < ways_eff);
  end

  // ---------------------------------------------------------------- address split
  logic [ADDR_W-1:0] shifted;
  logic [SET_W-1:0]  idx_mask;
  logic [SET_W-1:0]  set_in;
  logic [5:0]        split;
  logic [TAG_W-1:0]  tag_in;

  always_comb begin
    shifted  = req_i.address >> offset_w_q;
    // index widths at or above SET_W wrap the set modulo SETS
    idx_mask = ~({SET_W{1'b1}} << index_w_q);
    set_in   = shifted[SET_W-1:0] & idx_mask;
    split    = {1'b0, offset_w_q} + {3'b000, index_w_q};
    // a split of the whole word leaves no tag bits
    tag_in   = (split >= 6'd32) ? '0 : (req_i.address >> split);
  end

  // ---------------------------------------------------------------- control
  state_e           state_q;
  logic [SET_W-1:0] set_q;
  logic [TAG_W-1:0] tag_q;
  logic [SETS-1:0]  row_vld_q;
  logic             out_vld_q;
  logic             out_hit_q;
  logic [WAY_W-1:0] out_way_q;
  logic             out_fe_q;
  logic [CNT_W-1:0] hit_cnt_q;
  logic [CNT_W-1:0] miss_cnt_q;
  logic [CNT_W-1:0] acc_cnt_q;

  logic accept;
  assign req_i.ready = (state_q == S_IDLE);
  assign accept      = req_i.valid && req_i.ready;

  // ---------------------------------------------------------------- tag memory
  row_t rd_row_q;
  logic rd_fresh_q;
  row_t mem [SETS];
  row_t wr_row;
  logic mem_we;

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[set_q] <= wr_row;
  end

  // read issued at the accepting edge; no write is pending then
  always_ff @(posedge clk_i) begin
    if (accept) begin
      rd_row_q   <= mem[set_in];
      rd_fresh_q <= row_vld_q[set_in];
    end
  end

  // ---------------------------------------------------------------- lookup
  row_t            row_cur;
  logic [WAYS-1:0] hit_vec;
  logic [WAYS-1:0] empty_vec;
  logic            any_hit;
  logic            any_empty;
  logic [WAY_W-1:0] hit_idx;
  logic [WAY_W-1:0] empty_idx;
  logic [WAY_W-1:0] victim_way;
  logic [WAY_W-1:0] chosen;
  logic             out_free;
  logic             fin_look;
  logic             fin_evict;
  logic             finish;
  logic             hit_res;

  function automatic logic [WAY_W-1:0] first_one(input logic [WAYS-1:0] v);
    logic [WAY_W-1:0] idx;
    idx = '0;
    for (int i = WAYS - 1; i >= 0; i--) begin
      if (v[i]) idx = WAY_W'(i);
    end
    return idx;
  endfunction

  always_comb begin
    row_cur = rd_row_q;
    // a set never written since reset reads as empty with a zero counter
    if (!rd_fresh_q) begin
      row_cur.vld = '0;
      row_cur.ctr = '0;
    end
    for (int i = 0; i < WAYS; i++) begin
      hit_vec[i]   = way_en[i] && row_cur.vld[i] && (row_cur.tag[i] == tag_q);
      empty_vec[i] = way_en[i] && !row_cur.vld[i];
    end
    any_hit   = |hit_vec;
    any_empty = |empty_vec;
    hit_idx   = first_one(hit_vec);
    empty_idx = first_one(empty_vec);
  end

  // lru search over the stamps, only used when every searched way is valid
  slru_victim u_victim (
    .clk_i   (clk_i),
    .ld_i    (state_q == S_LOOK),
    .stamp_i (rd_row_q.stamp),
    .en_i    (way_en),
    .way_o   (victim_way)
  );

  always_comb begin
    out_free  = !out_vld_q || rsp_o.ready;
    fin_look  = (state_q == S_LOOK) && (any_hit || any_empty) && out_free;
    fin_evict = (state_q == S_EVICT) && out_free;
    finish    = fin_look || fin_evict;
    hit_res   = (state_q == S_LOOK) && any_hit;
    if (state_q == S_EVICT) chosen = victim_way;
    else if (any_hit)       chosen = hit_idx;
    else                    chosen = empty_idx;

    // read-modify-write of the set row
    wr_row = row_cur;
    if (!hit_res) begin
      wr_row.tag[chosen] = tag_q;
      wr_row.vld[chosen] = 1'b1;
    end
    wr_row.stamp[chosen] = row_cur.ctr;
    wr_row.ctr           = row_cur.ctr + 32'd1;
    mem_we = finish;
  end

  // ---------------------------------------------------------------- state and results
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      set_q      <= '0;
      tag_q      <= '0;
      row_vld_q  <= '0;
      out_vld_q  <= 1'b0;
      out_hit_q  <= 1'b0;
      out_way_q  <= '0;
      out_fe_q   <= 1'b0;
      hit_cnt_q  <= '0;
      miss_cnt_q <= '0;
      acc_cnt_q  <= '0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            set_q   <= set_in;
            tag_q   <= tag_in;
            state_q <= S_LOOK;
          end
        end
        S_LOOK: begin
          if (!any_hit && !any_empty) state_q <= S_EVICT;
          else if (out_free)         state_q <= S_IDLE;
        end
        S_EVICT: begin
          if (out_free) state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase

      // result register refills when an access finishes, drains on a transfer
      if (finish) begin
        row_vld_q[set_q] <= 1'b1;
        out_vld_q        <= 1'b1;
        out_hit_q        <= hit_res;
        out_way_q        <= chosen;
        out_fe_q         <= fin_look && !any_hit;
        acc_cnt_q        <= acc_cnt_q + 32'd1;
        if (hit_res) hit_cnt_q  <= hit_cnt_q + 32'd1;
        else         miss_cnt_q <= miss_cnt_q + 32'd1;
      end else if (rsp_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  assign rsp_o.valid           = out_vld_q;
  assign rsp_o.hit             = out_hit_q;
  assign rsp_o.way             = out_way_q;
  assign rsp_o.filled_empty    = out_fe_q;
  assign rsp_o.hits_so_far     = hit_cnt_q;
  assign rsp_o.misses_so_far   = miss_cnt_q;
  assign rsp_o.accesses_so_far = acc_cnt_q;

  // ---------------------------------------------------------------- checks
  `SLRU_ASSERT_IMP(a_cnt_sum, out_vld_q, CNT_W'(hit_cnt_q + miss_cnt_q) == acc_cnt_q,
    "hit and miss counts do not add up to the access count")
  `SLRU_ASSERT_IMP(a_hit_fill, out_vld_q, !(out_hit_q && out_fe_q),
    "result flags a hit and an empty fill together")
  `SLRU_ASSERT_NXT(a_fin_idle, finish, state_q == S_IDLE,
    "block did not return to idle after finishing an access")

endmodule

`default_nettype wire
